FILE: rtl/spq_pkg.sv
// shared constants, codes and command type for the stable priority queue
package spq_pkg;

  localparam int CAPACITY  = 16;
  localparam int PRIO_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // apply it to the store and register the result
  } cmd_t;

endpackage

FILE: rtl/spq_ctrl.sv
// sequencing state machine for the stable priority queue
module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_d = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy        = (state_q == ST_EXEC);
  assign done_o      = done_q;
  assign cmd_o.load  = (state_q == ST_IDLE) && start;
  assign cmd_o.exec  = (state_q == ST_EXEC);

endmodule

FILE: rtl/spq_datapath.sv
// sorted compare-and-shift cell array with transaction and result registers
module spq_datapath
  import spq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic                     op_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [PRIO_BITS-1:0]     priority_req_i,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [COUNT_W-1:0]       occupancy_o
);

  // captured transaction
  logic                 op_q;
  logic [DATA_W-1:0]    val_q;
  logic [PRIO_BITS-1:0] pri_q;

  // storage cells, front at index 0
  logic [DATA_W-1:0]    cell_val_q [CAPACITY];
  logic [PRIO_BITS-1:0] cell_pri_q [CAPACITY];
  logic [DATA_W-1:0]    cell_val_d [CAPACITY];
  logic [PRIO_BITS-1:0] cell_pri_d [CAPACITY];
  logic [COUNT_W-1:0]   count_q, count_d;

  logic [1:0]           stat_q, stat_d;
  logic [DATA_W-1:0]    data_q, data_d;

  logic [CAPACITY-1:0]  le;
  logic                 full, empty;

  assign full  = (count_q == COUNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      val_q <= value_i;
      pri_q <= priority_req_i;
    end
  end

  // cells that stay ahead of the new entry (stored and priority not above it)
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (COUNT_W'(i) < count_q) && (cell_pri_q[i] <= pri_q);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_val_d[i] = cell_val_q[i];
      cell_pri_d[i] = cell_pri_q[i];
    end
    count_d = count_q;
    stat_d  = STAT_OK;
    data_d  = '0;
    if (op_q == OP_ENQ) begin
      if (full) begin
        stat_d = STAT_FULL;
      end else begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!le[i]) begin
            if (i == 0) begin
              cell_val_d[i] = val_q;
              cell_pri_d[i] = pri_q;
            end else if (le[i-1]) begin
              cell_val_d[i] = val_q;
              cell_pri_d[i] = pri_q;
            end else begin
              cell_val_d[i] = cell_val_q[i-1];
              cell_pri_d[i] = cell_pri_q[i-1];
            end
          end
        end
        count_d = count_q + COUNT_W'(1);
      end
    end else begin
      if (empty) begin
        stat_d = STAT_EMPTY;
        data_d = '1;
      end else begin
        data_d = cell_val_q[0];
        for (int i = 0; i < CAPACITY - 1; i++) begin
          cell_val_d[i] = cell_val_q[i+1];
          cell_pri_d[i] = cell_pri_q[i+1];
        end
        count_d = count_q - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_val_q[i] <= cell_val_d[i];
        cell_pri_q[i] <= cell_pri_d[i];
      end
      stat_q <= stat_d;
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign status_o    = stat_q;
  assign data_out_o  = data_q;
  assign occupancy_o = count_q;

endmodule

FILE: rtl/stable_priority_queue.sv
// top level of the stable priority queue: controller, cell datapath, checks
//
// channel   direction  handshake                 payload
// command   in         start high, busy low      op_i, value_i, priority_req_i
// result    out        done_o for one cycle      status_o, data_out_o, occupancy_o
//
// a transaction is a capture, then one compare-and-shift pass over all
// 16 cells; done_o rises in the cycle after the pass, one result per transaction
// busy is high during the shift cycle only, so a new command can be taken in the
// same cycle the previous result is shown
// reset clears the controller and the entry count; cell contents stay unknown
// and are never shown before being written
// the receiver cannot stall: results are shown once and not held
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [PRIO_BITS-1:0]     priority_req_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [COUNT_W-1:0]       occupancy_o
);

  cmd_t cmd;

  // sequencing
  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // sorted cells and result registers
  spq_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .value_i        (value_i),
    .priority_req_i (priority_req_i),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .occupancy_o    (occupancy_o)
  );

  // an accepted transaction always moves to the shift cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not enter shift cycle");

  // every shift cycle is followed by exactly one result strobe
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("shift cycle not followed by result");

  // empty dequeue reports all ones and an empty store
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_EMPTY) |-> (occupancy_o == '0 && data_out_o == '1))
    else $error("empty dequeue result inconsistent");

  // a dropped enqueue only happens at full capacity
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_FULL) |-> (occupancy_o == COUNT_W'(CAPACITY)))
    else $error("full status with store not full");

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the stable priority queue: directed table, then random traffic
`timescale 1ns / 1ps

module testbench
  import spq_pkg::*;
();

  // one result of the queue, as the checker compares it
  typedef struct packed {
    logic [1:0]         status;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] occupancy;
  } result_t;

  // one row of the directed table; hand_checked rows carry a typed-in result
  typedef struct {
    logic                 op;
    logic [DATA_W-1:0]    value;
    logic [PRIO_BITS-1:0] prio;
    bit                   hand_checked;
    result_t              hand_result;
  } cmd_row_t;

  localparam int RANDOM_CMDS = 1500;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic                     op_i;
  logic signed [DATA_W-1:0] value_i;
  logic [PRIO_BITS-1:0]     priority_req_i;
  logic                     done_o;
  logic [1:0]               status_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic [COUNT_W-1:0]       occupancy_o;

  // shadow of the sorted store, front entry at index 0
  logic [DATA_W-1:0]    shadow_val [CAPACITY];
  logic [PRIO_BITS-1:0] shadow_pri [CAPACITY];
  int                   shadow_count;

  result_t  pending_results[$];
  cmd_row_t directed_rows[$];

  // row-side information handed to the monitor along with the command
  bit      row_checked;
  result_t row_result;

  int n_accepted;
  int n_checked;
  int n_errors;
  int n_enq;
  int n_deq;
  int n_empty_hits;
  int n_full_hits;
  int peak_count;

  stable_priority_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .value_i        (value_i),
    .priority_req_i (priority_req_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one command to the shadow store and work out the result it should give
  task automatic sorted_store_apply(input logic op, input logic [DATA_W-1:0] val,
                                    input logic [PRIO_BITS-1:0] pri, output result_t res);
    int slot;
    res = '0;
    if (op == OP_ENQ) begin
      if (shadow_count >= CAPACITY) begin
        // full store: the entry is dropped and nothing moves
        res.status = STAT_FULL;
      end else begin
        // equal priorities go behind the ones already stored, so ties leave in order
        slot = 0;
        while (slot < shadow_count && shadow_pri[slot] <= pri) slot++;
        for (int i = shadow_count; i > slot; i--) begin
          shadow_val[i] = shadow_val[i-1];
          shadow_pri[i] = shadow_pri[i-1];
        end
        shadow_val[slot] = val;
        shadow_pri[slot] = pri;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        // dequeue on empty: all ones out, store untouched
        res.status = STAT_EMPTY;
        res.data   = '1;
      end else begin
        res.data = shadow_val[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_val[i-1] = shadow_val[i];
          shadow_pri[i-1] = shadow_pri[i];
        end
        shadow_count--;
      end
    end
    res.occupancy = shadow_count[COUNT_W-1:0];
  endtask

  // monitor: results are checked first, then a transaction taken at this edge is predicted
  always @(posedge clk_i) begin
    result_t want;
    result_t guess;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result status=%0d data=%0d occupancy=%0d",
                 $time, status_o, data_out_o, occupancy_o);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (status_o !== want.status) begin
          n_errors++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status_o);
        end
        if (data_out_o !== want.data) begin
          n_errors++;
          $display("%0t: data_out mismatch, expected %0d, actual %0d",
                   $time, $signed(want.data), data_out_o);
        end
        if (occupancy_o !== want.occupancy) begin
          n_errors++;
          $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                   $time, want.occupancy, occupancy_o);
        end
      end
    end
    if (rst_ni && start && !busy) begin
      sorted_store_apply(op_i, value_i, priority_req_i, guess);
      // typed-in table rows override the shadow store's answer
      if (row_checked) guess = row_result;
      pending_results.push_back(guess);
      n_accepted++;
      if (op_i == OP_ENQ) n_enq++;
      else n_deq++;
      if (guess.status == STAT_EMPTY) n_empty_hits++;
      if (guess.status == STAT_FULL) n_full_hits++;
      if (shadow_count > peak_count) peak_count = shadow_count;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PRIO_BITS-1:0] pick_prio();
    case ($urandom_range(0, 3))
      0:       return PRIO_BITS'($urandom_range(0, 3));   // crowd of ties
      1:       return $urandom_range(0, 1) ? '1 : '0;     // extremes
      default: return PRIO_BITS'($urandom_range(0, (1 << PRIO_BITS) - 1));
    endcase
  endfunction

  task automatic add_row(input logic op, input logic [DATA_W-1:0] val,
                         input logic [PRIO_BITS-1:0] pri, input bit hand,
                         input logic [1:0] st, input logic [DATA_W-1:0] dat,
                         input int occ);
    cmd_row_t row;
    row.op                    = op;
    row.value                 = val;
    row.prio                  = pri;
    row.hand_checked          = hand;
    row.hand_result.status    = st;
    row.hand_result.data      = dat;
    row.hand_result.occupancy = occ[COUNT_W-1:0];
    directed_rows.push_back(row);
  endtask

  // called at a falling edge; returns at the falling edge after the transaction is taken
  task automatic send_cmd(input logic op, input logic [DATA_W-1:0] val,
                          input logic [PRIO_BITS-1:0] pri, input bit hand,
                          input result_t hand_res, input bit allow_gap);
    int gap;
    int target;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i           <= op;
    value_i        <= val;
    priority_req_i <= pri;
    row_checked    <= hand;
    row_result     <= hand_res;
    start          <= 1'b1;
    target = n_accepted + 1;
    while (n_accepted < target) @(negedge clk_i);
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  initial begin
    int       enq_pct;
    bit       no_gaps;
    int       guard;
    result_t  leftover;
    cmd_row_t row;

    rst_ni         = 1'b0;
    start          = 1'b0;
    op_i           = OP_ENQ;
    value_i        = '0;
    priority_req_i = '0;
    row_checked    = 1'b0;
    row_result     = '0;
    shadow_count   = 0;
    n_accepted     = 0;
    n_checked      = 0;
    n_errors       = 0;
    n_enq          = 0;
    n_deq          = 0;
    n_empty_hits   = 0;
    n_full_hits    = 0;
    peak_count     = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_val[i] = '0;
      shadow_pri[i] = '0;
    end

    // directed table: empty, extremes, ordering, ties, full store
    add_row(OP_DEQ, 32'h1234_5678, 8'hFF, 1, STAT_EMPTY, 32'hFFFF_FFFF, 0);
    add_row(OP_ENQ, 32'h7FFF_FFFF, 8'hFF, 1, STAT_OK, 32'h0, 1);
    add_row(OP_ENQ, 32'h8000_0000, 8'h00, 1, STAT_OK, 32'h0, 2);
    add_row(OP_DEQ, 32'hFFFF_FFFF, 8'h00, 1, STAT_OK, 32'h8000_0000, 1);
    add_row(OP_DEQ, 32'h0, 8'h00, 1, STAT_OK, 32'h7FFF_FFFF, 0);
    add_row(OP_DEQ, 32'h0, 8'h00, 1, STAT_EMPTY, 32'hFFFF_FFFF, 0);
    // fill with priorities 0, 85, 170, 255 repeating, so every level holds ties
    for (int i = 0; i < CAPACITY; i++)
      add_row(OP_ENQ, 32'd1000 + i, 8'd85 * i[1:0], 1, STAT_OK, 32'h0, i + 1);
    add_row(OP_ENQ, 32'hDEAD_BEEF, 8'h00, 1, STAT_FULL, 32'h0, CAPACITY);
    add_row(OP_DEQ, 32'h0, 8'h00, 0, STAT_OK, 32'h0, 0);
    add_row(OP_DEQ, 32'h0, 8'h00, 0, STAT_OK, 32'h0, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_cmd(row.op, row.value, row.prio, row.hand_checked, row.hand_result, 1'b1);
    end
    drain_results();

    // random traffic: the enqueue mix shifts so the store swings between empty and full
    enq_pct = 50;
    no_gaps = 1'b0;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 20;
          1:       enq_pct = 50;
          default: enq_pct = 85;
        endcase
      end
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (n > 0 && n % 300 == 0) drain_results();
      send_cmd(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ,
               pick_value(), pick_prio(), 1'b0, '0, !no_gaps);
    end

    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(negedge clk_i);
      guard++;
    end
    // keep the clock running to catch stray results
    repeat (10) @(posedge clk_i);

    while (pending_results.size() != 0) begin
      leftover = pending_results.pop_front();
      n_errors++;
      $display("%0t: missing result, expected status=%0d data=%0d occupancy=%0d",
               $time, leftover.status, $signed(leftover.data), leftover.occupancy);
    end

    $display("run covered %0d transactions (%0d enqueue, %0d dequeue), %0d results checked",
             n_accepted, n_enq, n_deq, n_checked);
    $display("dequeues on empty: %0d, enqueues into full store: %0d, peak fill %0d of %0d",
             n_empty_hits, n_full_hits, peak_count, CAPACITY);
    if (n_errors == 0) begin
      $display("** stable_priority_queue: PASSED **");
    end else begin
      $display("** stable_priority_queue: FAILED **");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("** stable_priority_queue: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/stable_priority_queue.sv
tb/sv/testbench.sv
